// ===== sv/kpvf_pkg.sv =====
// ============================================================================
// kpvf_pkg: shared types and constants
// Opcodes and control structs of the position and velocity fusion block.
// ============================================================================
package kpvf_pkg;

    localparam int W  = 48;
    localparam int IW = 32;

    localparam logic signed [W-1:0] MAX48 = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN48 = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
    } t_req;

    typedef struct packed {
        logic                done;
        logic signed [W-1:0] res;
    } t_rsp;

    localparam logic [2:0] REG_QP   = 3'd0;
    localparam logic [2:0] REG_QV   = 3'd1;
    localparam logic [2:0] REG_RF   = 3'd2;
    localparam logic [2:0] REG_RS   = 3'd3;
    localparam logic [2:0] REG_INIT = 3'd4;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                     input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s > $signed({1'b0, MAX48})) return MAX48;
        if (s < $signed({1'b1, MIN48})) return MIN48;
        return s[W-1:0];
    endfunction

    // The three operands are summed at full width and saturated once.
    function automatic logic signed [W-1:0] sat_add3(input logic signed [W-1:0] x,
                                                      input logic signed [W-1:0] y,
                                                      input logic signed [W-1:0] z);
        logic signed [W+1:0] s;
        s = {{2{x[W-1]}}, x} + {{2{y[W-1]}}, y} + {{2{z[W-1]}}, z};
        if (s > $signed({2'b00, MAX48})) return MAX48;
        if (s < $signed({2'b11, MIN48})) return MIN48;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                     input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        if (s > $signed({1'b0, MAX48})) return MAX48;
        if (s < $signed({1'b1, MIN48})) return MIN48;
        return s[W-1:0];
    endfunction

endpackage

// ===== sv/kpvf_if.sv =====
// ============================================================================
// kpvf_if: valid and ready channel
// Carries one payload beat from a source to a sink.
// ============================================================================
interface kpvf_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/kpvf_alu.sv =====
// ============================================================================
// kpvf_alu: shared sequential multiplier and divider
// Multiplies by shift and add, one bit per cycle, or divides by restoring
// division, one quotient bit per cycle, on magnitudes, then saturates.
// ============================================================================
module kpvf_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kpvf_pkg::t_req i_req,
    output kpvf_pkg::t_rsp o_rsp
);
    localparam int W  = kpvf_pkg::W;
    localparam int PW = 2 * W;
    localparam int NW = W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic              r_busy, n_busy;
    kpvf_pkg::t_op     r_op, n_op;
    logic              r_neg, n_neg;
    logic [W-1:0]      r_x, n_x;
    logic [W-1:0]      r_y, n_y;
    logic [PW-1:0]     r_acc, n_acc;
    logic [NW-1:0]     r_num, n_num;
    logic [W:0]        r_rem, n_rem;
    logic [NW-1:0]     r_q, n_q;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_done, n_done;
    logic signed [W-1:0] r_res, n_res;

    logic [W-1:0]  w_ma, w_mb;
    logic [W:0]    w_sh;
    logic [PW-1:0] w_rnd;
    logic [PW-1:0] w_mag;
    logic          w_ovf;
    logic [W-1:0]  w_m;

    assign w_ma = i_req.a[W-1] ? W'(-i_req.a) : W'(i_req.a);
    assign w_mb = i_req.b[W-1] ? W'(-i_req.b) : W'(i_req.b);
    assign w_sh = {r_rem[W-1:0], r_num[NW-1]};
    assign w_rnd = r_acc + (PW'(1) << (FRAC_BITS - 1));

    always_comb begin
        if (r_op == kpvf_pkg::OP_MUL) begin
            w_mag = w_rnd >> FRAC_BITS;
            w_ovf = |w_mag[PW-1:W];
            w_m   = w_mag[W-1:0];
        end else begin
            w_mag = '0;
            w_ovf = |r_q[NW-1:W];
            w_m   = r_q[W-1:0];
        end
    end

    always_comb begin
        n_busy = r_busy; n_op = r_op; n_neg = r_neg; n_x = r_x; n_y = r_y;
        n_acc = r_acc; n_num = r_num; n_rem = r_rem; n_q = r_q; n_cnt = r_cnt;
        n_done = 1'b0; n_res = r_res;
        if (!r_busy) begin
            if (i_req.start) begin
                n_op  = i_req.op;
                n_neg = i_req.a[W-1] ^ i_req.b[W-1];
                n_acc = '0;
                n_rem = '0;
                n_q   = '0;
                if (i_req.op == kpvf_pkg::OP_DIV && w_mb == '0) begin
                    n_done = 1'b1;
                    n_res  = '0;
                end else begin
                    n_busy = 1'b1;
                    n_x    = w_ma;
                    n_y    = w_mb;
                    n_num  = {w_ma, {FRAC_BITS{1'b0}}};
                    n_cnt  = (i_req.op == kpvf_pkg::OP_MUL) ? CW'(W) : CW'(NW);
                end
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (r_op == kpvf_pkg::OP_MUL) begin
                if (r_y[0]) n_acc = r_acc + (PW'(r_x) << W);
                else        n_acc = r_acc;
                n_acc = {1'b0, n_acc[PW-1:1]};
                n_y   = {1'b0, r_y[W-1:1]};
            end else begin
                n_num = {r_num[NW-2:0], 1'b0};
                if (w_sh >= {1'b0, r_y}) begin
                    n_rem = w_sh - {1'b0, r_y};
                    n_q   = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_rem = w_sh;
                    n_q   = {r_q[NW-2:0], 1'b0};
                end
            end
        end else begin
            n_busy = 1'b0;
            n_done = 1'b1;
            if (r_neg) n_res = (w_ovf || w_m[W-1]) ? kpvf_pkg::MIN48 : -$signed(w_m);
            else       n_res = (w_ovf || w_m[W-1]) ? kpvf_pkg::MAX48 : $signed(w_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= kpvf_pkg::OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_neg <= n_neg; r_x <= n_x; r_y <= n_y; r_acc <= n_acc;
        r_num <= n_num; r_rem <= n_rem; r_q <= n_q; r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("done raised while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(i_req.start)) else $error("done not a pulse");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0) |=> !r_busy && r_done) else $error("no finish");
`endif
endmodule

// ===== sv/kpvf_seq.sv =====
// ============================================================================
// kpvf_seq: update sequencer
// Steps through the filter equations, issuing each product and quotient to
// the shared unit and doing the saturated adds between them.
// ============================================================================
module kpvf_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  logic signed [47:0]       i_init_position,
    input  logic [31:0]              i_q_position,
    input  logic [31:0]              i_q_velocity,
    input  logic [47:0]              i_r,
    input  logic                     i_start,
    input  logic signed [31:0]       i_meas_position,
    input  logic signed [31:0]       i_meas_velocity,
    input  logic [31:0]              i_time_step,
    output logic                     o_busy,
    output logic                     o_done,
    output logic signed [47:0]       o_est_position,
    output logic signed [47:0]       o_est_velocity,
    output kpvf_pkg::t_req           o_req,
    input  kpvf_pkg::t_rsp           i_rsp
);
    localparam int W = kpvf_pkg::W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MPOS  = 13'b0000000000010,
        S_MDVV  = 13'b0000000000100,
        S_MINN  = 13'b0000000001000,
        S_PRED  = 13'b0000000010000,
        S_DK0   = 13'b0000000100000,
        S_DK1   = 13'b0000001000000,
        S_CP    = 13'b0000010000000,
        S_CV    = 13'b0000100000000,
        S_CPP   = 13'b0001000000000,
        S_CPV   = 13'b0010000000000,
        S_CVP   = 13'b0100000000000,
        S_CVV   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_issue, n_issue;
    logic signed [W-1:0] r_pos, r_vel, r_pp, r_pv, r_vp, r_vv;
    logic signed [W-1:0] n_pos, n_vel, n_pp, n_pv, n_vp, n_vv;
    logic signed [W-1:0] r_dt, r_mp, r_qp, r_qv, r_dvv, r_k0, r_k1, r_y;
    logic [W-1:0]        r_r;
    logic signed [W-1:0] n_dvv, n_k0, n_k1, n_y;
    logic signed [W-1:0] r_pp0, r_pv0, n_pp0, n_pv0;
    logic signed [W-1:0] w_res;
    logic                w_ack;
    logic signed [W+1:0] w_s_full;
    logic signed [W-1:0] w_s;

    assign w_res = i_rsp.res;
    assign w_ack = i_rsp.done;

    // The noise term is unsigned and can exceed the signed range on its own.
    assign w_s_full = {{2{r_pp[W-1]}}, r_pp} + {2'b00, r_r};
    assign w_s      = (w_s_full > $signed({2'b00, kpvf_pkg::MAX48})) ? kpvf_pkg::MAX48
                                                                     : w_s_full[W-1:0];

    always_comb begin
        o_req.start = r_issue;
        o_req.op    = kpvf_pkg::OP_MUL;
        o_req.a     = r_dt;
        o_req.b     = r_vel;
        unique case (r_state)
            S_MDVV:  o_req.b = r_vv;
            S_MINN:  o_req.b = kpvf_pkg::sat_add3(r_dvv, r_pv, r_vp);
            S_DK0:   begin
                o_req.op = kpvf_pkg::OP_DIV; o_req.a = r_pp;
                o_req.b  = w_s;
            end
            S_DK1:   begin
                o_req.op = kpvf_pkg::OP_DIV; o_req.a = r_vp;
                o_req.b  = w_s;
            end
            S_CP:    begin o_req.a = r_k0; o_req.b = r_y;   end
            S_CV:    begin o_req.a = r_k1; o_req.b = r_y;   end
            S_CPP:   begin o_req.a = r_k0; o_req.b = r_pp0; end
            S_CPV:   begin o_req.a = r_k0; o_req.b = r_pv0; end
            S_CVP:   begin o_req.a = r_k1; o_req.b = r_pp0; end
            S_CVV:   begin o_req.a = r_k1; o_req.b = r_pv0; end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state; n_issue = 1'b0; o_done = 1'b0;
        n_pos = r_pos; n_vel = r_vel; n_pp = r_pp; n_pv = r_pv; n_vp = r_vp; n_vv = r_vv;
        n_dvv = r_dvv; n_k0 = r_k0; n_k1 = r_k1; n_y = r_y; n_pp0 = r_pp0; n_pv0 = r_pv0;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                n_vel = W'(i_meas_velocity);
                n_state = S_MPOS; n_issue = 1'b1;
            end
            S_MPOS: if (w_ack) begin
                n_pos = kpvf_pkg::sat_add(r_pos, w_res);
                n_state = S_MDVV; n_issue = 1'b1;
            end
            S_MDVV: if (w_ack) begin
                n_dvv = w_res; n_state = S_MINN; n_issue = 1'b1;
            end
            S_MINN: if (w_ack) begin
                n_pp = kpvf_pkg::sat_add3(r_pp, w_res, r_qp);
                n_state = S_PRED;
            end
            S_PRED: begin
                n_pv = kpvf_pkg::sat_add3(r_pv, r_dvv, r_qp);
                n_vp = kpvf_pkg::sat_add3(r_vp, r_dvv, r_qv);
                n_vv = kpvf_pkg::sat_add(r_vv, r_qv);
                n_y  = kpvf_pkg::sat_sub(r_mp, r_pos);
                n_state = S_DK0; n_issue = 1'b1;
            end
            S_DK0: if (w_ack) begin
                n_k0 = w_res; n_state = S_DK1; n_issue = 1'b1;
            end
            S_DK1: if (w_ack) begin
                n_k1 = w_res; n_pp0 = r_pp; n_pv0 = r_pv;
                n_state = S_CP; n_issue = 1'b1;
            end
            S_CP: if (w_ack) begin
                n_pos = kpvf_pkg::sat_add(r_pos, w_res); n_state = S_CV; n_issue = 1'b1;
            end
            S_CV: if (w_ack) begin
                n_vel = kpvf_pkg::sat_add(r_vel, w_res); n_state = S_CPP; n_issue = 1'b1;
            end
            S_CPP: if (w_ack) begin
                n_pp = kpvf_pkg::sat_sub(r_pp, w_res); n_state = S_CPV; n_issue = 1'b1;
            end
            S_CPV: if (w_ack) begin
                n_pv = kpvf_pkg::sat_sub(r_pv, w_res); n_state = S_CVP; n_issue = 1'b1;
            end
            S_CVP: if (w_ack) begin
                n_vp = kpvf_pkg::sat_sub(r_vp, w_res); n_state = S_CVV; n_issue = 1'b1;
            end
            S_CVV: if (w_ack) begin
                n_vv = kpvf_pkg::sat_sub(r_vv, w_res); n_state = S_IDLE; o_done = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
        end
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0; r_pp <= '0; r_pv <= '0; r_vp <= '0; r_vv <= '0;
        end else if (i_restart) begin
            r_pos <= i_init_position;
            r_vel <= '0; r_pp <= '0; r_pv <= '0; r_vp <= '0; r_vv <= '0;
        end else begin
            r_pos <= n_pos; r_vel <= n_vel; r_pp <= n_pp;
            r_pv  <= n_pv;  r_vp  <= n_vp;  r_vv <= n_vv;
        end
        if (r_state == S_IDLE && i_start) begin
            r_dt <= W'($unsigned(i_time_step));
            r_mp <= W'(i_meas_position);
            r_r  <= i_r;
            r_qp <= W'($unsigned(i_q_position));
            r_qv <= W'($unsigned(i_q_velocity));
        end
        r_dvv <= n_dvv; r_k0 <= n_k0; r_k1 <= n_k1; r_y <= n_y;
        r_pp0 <= n_pp0; r_pv0 <= n_pv0;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_est_position = n_pos;
    assign o_est_velocity = n_vel;

`ifndef SYNTHESIS
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> r_state != S_IDLE) else $error("issue while idle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE) else $error("not idle after done");
    a_start_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_MPOS) else $error("start lost");
`endif
endmodule

// ===== sv/kalman_position_velocity_fusion.sv =====
// ============================================================================
// kalman_position_velocity_fusion: two-state position and velocity filter
// Fuses position and velocity measurements with a shared multiply and
// divide unit under a sequencer.
// ============================================================================
//  channel   dir  payload
//  in_ch     in   meas_position, meas_velocity, time_step, fresh_measurement
//  out_ch    out  est_position, est_velocity
//  config    in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// One beat runs 9 products and 2 quotients through the shared unit (a quotient
// by a zero S skips the division and gives zero), plus an accept and a predict
// step in the sequencer, and the result is then registered for output; input
// ready is low meanwhile. A new beat is accepted only when the output register
// is empty or being taken in the same cycle.
// Reset is synchronous and restores control, filter state and configuration.
module kalman_position_velocity_fusion #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [47:0]  i_cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  i_meas_position,
    input  logic [31:0]  i_meas_velocity,
    input  logic [31:0]  i_time_step,
    input  logic         i_fresh_measurement,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [47:0]  o_est_position,
    output logic [47:0]  o_est_velocity
);
    logic [31:0] r_qp, r_qv;
    logic [47:0] r_rf, r_rs, r_init;
    logic        w_restart, w_start, w_busy, w_done;
    logic signed [47:0] w_pos, w_vel;
    logic        r_ov;
    logic [47:0] r_op, r_ovl;
    kpvf_pkg::t_req w_req;
    kpvf_pkg::t_rsp w_rsp;

    assign w_restart = i_cfg_we && (i_cfg_idx <= kpvf_pkg::REG_INIT);
    assign in_ready  = !w_busy && !(r_ov && !out_ready) ? 1'b1 : 1'b0;
    assign w_start   = in_valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qp <= '0; r_qv <= 32'd6554; r_rf <= 48'd13107; r_rs <= 48'd1310720;
            r_init <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kpvf_pkg::REG_QP:   r_qp   <= i_cfg_data[31:0];
                kpvf_pkg::REG_QV:   r_qv   <= i_cfg_data[31:0];
                kpvf_pkg::REG_RF:   r_rf   <= i_cfg_data;
                kpvf_pkg::REG_RS:   r_rs   <= i_cfg_data;
                kpvf_pkg::REG_INIT: r_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kpvf_seq u_seq (
        .i_clk, .i_rst_n,
        .i_restart       (w_restart),
        .i_init_position ($signed(w_restart && i_cfg_idx == kpvf_pkg::REG_INIT
                                  ? i_cfg_data : r_init)),
        .i_q_position    (r_qp),
        .i_q_velocity    (r_qv),
        .i_r             (i_fresh_measurement ? r_rf : r_rs),
        .i_start         (w_start),
        .i_meas_position ($signed(i_meas_position)),
        .i_meas_velocity ($signed(i_meas_velocity)),
        .i_time_step     (i_time_step),
        .o_busy          (w_busy),
        .o_done          (w_done),
        .o_est_position  (w_pos),
        .o_est_velocity  (w_vel),
        .o_req           (w_req),
        .i_rsp           (w_rsp)
    );

    kpvf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_done) r_ov <= 1'b1;
        else if (out_ready) r_ov <= 1'b0;
        if (w_done) begin
            r_op  <= w_pos;
            r_ovl <= w_vel;
        end
    end

    assign out_valid      = r_ov;
    assign o_est_position = r_op;
    assign o_est_velocity = r_ovl;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !in_ready) else $error("accepted while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> out_valid) else $error("result lost");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !(r_ov && !out_ready)) else $error("result overwritten");
`endif
endmodule

// ===== tb/tb_kalman_position_velocity_fusion.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_kalman_position_velocity_fusion: regression for the fusion filter
// Drives measurement beats through bursty traffic and a stalling receiver,
// predicts every position and velocity estimate in fixed point, and compares
// each output beat against the oldest prediction over several register sets.
// ============================================================================
module tb_kalman_position_velocity_fusion;

    localparam longint SAT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO    = -64'sh0000_8000_0000_0000;
    localparam int     FRAC      = 16;
    localparam longint LIMIT     = 64'd12_000_000;
    localparam int     PER_PHASE = 230;

    typedef struct packed {
        logic [31:0] mp;
        logic [31:0] mv;
        logic [31:0] dt;
        logic        fresh;
    } in_beat_t;

    typedef struct packed {
        logic [47:0] pos;
        logic [47:0] vel;
    } est_beat_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [47:0] i_cfg_data;

    kpvf_if #(.T(in_beat_t))  in_ch ();
    kpvf_if #(.T(est_beat_t)) out_ch ();

    kalman_position_velocity_fusion dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .in_valid            (in_ch.valid),
        .in_ready            (in_ch.ready),
        .i_meas_position     (in_ch.data.mp),
        .i_meas_velocity     (in_ch.data.mv),
        .i_time_step         (in_ch.data.dt),
        .i_fresh_measurement (in_ch.data.fresh),
        .out_valid           (out_ch.valid),
        .out_ready           (out_ch.ready),
        .o_est_position      (out_ch.data.pos),
        .o_est_velocity      (out_ch.data.vel)
    );

    // Filter state and registers mirrored by the predictor.
    longint q_pos_r, q_vel_r, r_fresh_r, r_stale_r, init_pos_r;
    longint pos_s, vel_s, pp_s, pv_s, vp_s, vv_s;

    in_beat_t  meas_q[$];
    est_beat_t est_q[$];
    int        errors;
    longint    cycles;
    logic      in_taken;
    int        gap_cnt, burst_cnt, hold_cnt, stall_mode, mode_cnt;
    logic      quiet_rx;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat48(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic logic [127:0] magnitude(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint saturate_mag(bit neg, logic [127:0] m);
        if (neg) begin
            if (m >= (128'd1 << 47)) return SAT_LO;
            return -longint'(m[63:0]);
        end
        if (m > 128'(SAT_HI)) return SAT_HI;
        return longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = magnitude(a) * magnitude(b) + (128'd1 << (FRAC - 1));
        return saturate_mag((a < 0) != (b < 0), p >> FRAC);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] d;
        d = magnitude(b);
        if (d == 0) return 0;
        return saturate_mag((a < 0) != (b < 0), (magnitude(a) << FRAC) / d);
    endfunction

    task automatic restart_filter();
        pos_s = init_pos_r;
        vel_s = 0; pp_s = 0; pv_s = 0; vp_s = 0; vv_s = 0;
    endtask

    task automatic apply_register(logic [2:0] idx, logic [47:0] val);
        case (idx)
            kpvf_pkg::REG_QP:   q_pos_r = longint'(val[31:0]);
            kpvf_pkg::REG_QV:   q_vel_r = longint'(val[31:0]);
            kpvf_pkg::REG_RF:   r_fresh_r = longint'({16'd0, val});
            kpvf_pkg::REG_RS:   r_stale_r = longint'({16'd0, val});
            kpvf_pkg::REG_INIT: init_pos_r = longint'($signed(val));
            default: return;
        endcase
        restart_filter();
    endtask

    function automatic est_beat_t fuse_measurement(in_beat_t m);
        longint mp, dt, r, dvv, inner, y, s, k0, k1, pp0, pv0;
        est_beat_t e;
        mp = longint'($signed(m.mp));
        dt = longint'({32'd0, m.dt});
        r  = m.fresh ? r_fresh_r : r_stale_r;
        vel_s = longint'($signed(m.mv));
        pos_s = sat48(pos_s + fx_mul(dt, vel_s));
        dvv   = fx_mul(dt, vv_s);
        inner = sat48(dvv + pv_s + vp_s);
        pp_s  = sat48(pp_s + fx_mul(dt, inner) + q_pos_r);
        pv_s  = sat48(pv_s + dvv + q_pos_r);
        vp_s  = sat48(vp_s + dvv + q_vel_r);
        vv_s  = sat48(vv_s + q_vel_r);
        y  = sat48(mp - pos_s);
        s  = sat48(pp_s + r);
        k0 = fx_div(pp_s, s);
        k1 = fx_div(vp_s, s);
        pos_s = sat48(pos_s + fx_mul(k0, y));
        vel_s = sat48(vel_s + fx_mul(k1, y));
        pp0 = pp_s;
        pv0 = pv_s;
        pp_s = sat48(pp_s - fx_mul(k0, pp0));
        pv_s = sat48(pv_s - fx_mul(k0, pv0));
        vp_s = sat48(vp_s - fx_mul(k1, pp0));
        vv_s = sat48(vv_s - fx_mul(k1, pv0));
        e.pos = pos_s[47:0];
        e.vel = vel_s[47:0];
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Monitor: register writes, accepted measurements and estimate beats.
    always @(posedge i_clk) begin
        est_beat_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("kalman_position_velocity_fusion regression: fail");
            $finish;
        end
        in_taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (i_cfg_we) apply_register(i_cfg_idx, i_cfg_data);
            if (in_ch.valid && in_ch.ready) est_q.push_back(fuse_measurement(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (est_q.size() == 0) begin
                    report_mismatch("unexpected beat", out_ch.data.pos, '0);
                end else begin
                    want = est_q.pop_front();
                    if (out_ch.data.pos !== want.pos)
                        report_mismatch("est_position", out_ch.data.pos, want.pos);
                    if (out_ch.data.vel !== want.vel)
                        report_mismatch("est_velocity", out_ch.data.vel, want.vel);
                end
            end
        end
    end

    // Driver: bursts of beats separated by random gaps.
    always @(negedge i_clk) begin
        logic     nxt_valid;
        in_beat_t nxt;
        nxt_valid = in_ch.valid;
        nxt = in_ch.data;
        if (i_rst_n !== 1'b1) begin
            nxt_valid = 1'b0;
        end else if (in_taken || !in_ch.valid) begin
            nxt_valid = 1'b0;
            if (gap_cnt > 0) begin
                gap_cnt--;
            end else if (meas_q.size() > 0) begin
                nxt = meas_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_cnt > 0) begin
                    burst_cnt--;
                end else begin
                    burst_cnt = $urandom_range(0, 8);
                    gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1200);
                end
            end
        end
        in_ch.valid <= nxt_valid;
        in_ch.data  <= nxt;
    end

    // Receiver: stall pattern of its own, plus an occasional long hold-off.
    always @(negedge i_clk) begin
        logic rdy;
        if (mode_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_cnt = $urandom_range(50, 3000);
        end else begin
            mode_cnt--;
        end
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 15) == 0);
            default: rdy = ($urandom_range(0, 7) != 0);
        endcase
        if (quiet_rx) begin
            rdy = 1'b0;
            if (hold_cnt > 0) hold_cnt--;
        end
        out_ch.ready <= rdy;
    end

    function automatic in_beat_t random_measurement(ref longint track);
        in_beat_t m;
        if ($urandom_range(0, 9) < 7) begin
            track = track + longint'($urandom_range(0, 2000)) - 1000;
            if (track > 64'sd2000000000 || track < -64'sd2000000000) track = 0;
            m.mp = 32'(track + longint'($urandom_range(0, 600)) - 300);
            m.mv = 32'(longint'($urandom_range(0, 400000)) - 200000);
            m.dt = $urandom_range(0, 13107);
        end else begin
            m.mp = $urandom;
            m.mv = $urandom;
            m.dt = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 65536 * 4);
        end
        m.fresh = 1'($urandom_range(0, 1));
        return m;
    endfunction

    task automatic wait_drained();
        while (meas_q.size() != 0 || in_ch.valid || est_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_registers(logic [31:0] qp, logic [31:0] qv, logic [47:0] rf,
                                  logic [47:0] rs, logic [47:0] init);
        write_register(kpvf_pkg::REG_QP, {16'd0, qp});
        write_register(kpvf_pkg::REG_QV, {16'd0, qv});
        write_register(kpvf_pkg::REG_RF, rf);
        write_register(kpvf_pkg::REG_RS, rs);
        write_register(kpvf_pkg::REG_INIT, init);
    endtask

    initial begin
        longint   track;
        in_beat_t m;
        logic [31:0] edge_val [4];
        errors = 0; cycles = 0; in_taken = 1'b0;
        gap_cnt = 0; burst_cnt = 0; hold_cnt = 0; mode_cnt = 0; stall_mode = 0;
        quiet_rx = 1'b0; track = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
        q_pos_r = 0; q_vel_r = 6554; r_fresh_r = 13107; r_stale_r = 1310720;
        init_pos_r = 0;
        restart_filter();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes at reset register values.
        edge_val[0] = 32'h0000_0000; edge_val[1] = 32'hFFFF_FFFF;
        edge_val[2] = 32'h7FFF_FFFF; edge_val[3] = 32'h8000_0000;
        for (int k = 0; k < 16; k++) begin
            m.mp = edge_val[k % 4];
            m.mv = edge_val[(k / 4) % 4];
            m.dt = (k % 3 == 0) ? 32'd0 : (k % 3 == 1) ? 32'hFFFF_FFFF : 32'h0001_0000;
            m.fresh = k[0];
            meas_q.push_back(m);
        end
        wait_drained();

        // Zero innovation variance: no noise at all, so S stays zero.
        load_registers(32'd0, 32'd0, 48'd0, 48'd0, 48'd0);
        for (int k = 0; k < 6; k++) begin
            m.mp = $urandom; m.mv = $urandom; m.dt = $urandom_range(0, 70000);
            m.fresh = k[0];
            meas_q.push_back(m);
        end
        wait_drained();

        // Out-of-range indexes must leave the filter running undisturbed.
        for (int k = 0; k < 4; k++) meas_q.push_back(random_measurement(track));
        while (meas_q.size() != 0 || in_ch.valid || est_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        write_register(3'd5, 48'({$urandom, $urandom}));
        write_register(3'd6, 48'({$urandom, $urandom}));
        write_register(3'd7, 48'({$urandom, $urandom}));
        for (int k = 0; k < 4; k++) meas_q.push_back(random_measurement(track));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_registers(32'd0, 32'd6554, 48'd13107, 48'd1310720, 48'd0);
                1: load_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                  48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
                2: load_registers(32'd0, 32'd0, 48'd0, 48'd1, 48'h8000_0000_0000);
                3: load_registers(32'd655, 32'd6554, 48'd6554, 48'd655360,
                                  48'hFFFF_FFF0_0000);
                default: load_registers($urandom, $urandom_range(0, 100000),
                                        48'({$urandom, $urandom}),
                                        48'({$urandom, $urandom}),
                                        48'({$urandom, $urandom}));
            endcase
            track = 0;
            for (int k = 0; k < PER_PHASE; k++) meas_q.push_back(random_measurement(track));
            if (ph == 4) begin
                // Long receiver hold-off while the sender keeps offering beats.
                hold_cnt = 4000;
                quiet_rx = 1'b1;
                gap_cnt = 0;
                while (hold_cnt > 0) @(posedge i_clk);
                quiet_rx = 1'b0;
            end
            if (ph == 6) begin
                // Sender pause mid-phase until every estimate has come back.
                while (meas_q.size() > PER_PHASE / 2) @(posedge i_clk);
                begin
                    in_beat_t held[$];
                    held = meas_q;
                    meas_q.delete();
                    while (in_ch.valid || est_q.size() != 0) @(posedge i_clk);
                    meas_q = held;
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("kalman_position_velocity_fusion regression: pass");
        end else begin
            $display("kalman_position_velocity_fusion regression: fail");
        end
        $finish;
    end
endmodule

// ===== kalman_position_velocity_fusion.f =====
sv/kpvf_pkg.sv
sv/kpvf_if.sv
sv/kpvf_alu.sv
sv/kpvf_seq.sv
sv/kalman_position_velocity_fusion.sv
tb/tb_kalman_position_velocity_fusion.sv
